>>> rtl/trs_pkg.sv
// Shared types, constants and helper functions for the pivot TRS matrix composer.
package trs_pkg;

    localparam int ACC_W     = 100;
    localparam int ANG_W     = 34;
    localparam int OPB_W     = 36;
    localparam int CW        = 21;
    localparam int REG_W     = 63;
    localparam int ELEM_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_W-1:0] SCALE_RST  = 63'd4503601774855168;
    localparam logic [CW-1:0]    USCALE_RST = 21'd1024;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCALE  = 3'd0,
        REG_USCALE = 3'd1,
        REG_ROT    = 3'd2,
        REG_TRANS  = 3'd3,
        REG_PIVOT  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] scale;
        logic [CW-1:0]    uscale;
        logic [REG_W-1:0] rot;
        logic [REG_W-1:0] trans;
        logic [REG_W-1:0] pivot;
    } cfg_t;

    typedef logic [15:0][ELEM_W-1:0] mat_t;

    function automatic logic signed [CW-1:0] comp(input logic [REG_W-1:0] v,
                                                  input logic [1:0] k);
        logic signed [CW-1:0] c;
        case (k)
            2'd0:    c = v[20:0];
            2'd1:    c = v[41:21];
            2'd2:    c = v[62:42];
            default: c = '0;
        endcase
        return c;
    endfunction

    // arctangent of 2^-i, Q2.30, truncated
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 34'sd843314856;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043836;
            5'd3:    a = 34'sd133525158;
            5'd4:    a = 34'sd67021686;
            5'd5:    a = 34'sd33543515;
            5'd6:    a = 34'sd16775850;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194282;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048575;
            5'd11:   a = 34'sd524287;
            5'd12:   a = 34'sd262143;
            5'd13:   a = 34'sd131071;
            5'd14:   a = 34'sd65535;
            5'd15:   a = 34'sd32767;
            5'd16:   a = 34'sd16383;
            5'd17:   a = 34'sd8191;
            5'd18:   a = 34'sd4095;
            5'd19:   a = 34'sd2047;
            5'd20:   a = 34'sd1023;
            5'd21:   a = 34'sd511;
            5'd22:   a = 34'sd255;
            5'd23:   a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

    // floor shift of a rounded accumulator, then saturate to 32 bits
    function automatic logic [ELEM_W-1:0] sat32(input logic signed [ACC_W-1:0] v,
                                                input int unsigned sh);
        logic signed [ACC_W-1:0] t;
        logic [ELEM_W-1:0] r;
        t = v >>> sh;
        if ((t[ACC_W-1:ELEM_W-1] == '0) || (t[ACC_W-1:ELEM_W-1] == '1))
            r = t[ELEM_W-1:0];
        else if (t[ACC_W-1])
            r = 32'h8000_0000;
        else
            r = 32'h7fff_ffff;
        return r;
    endfunction

endpackage

>>> rtl/pivot_trs_matrix_compose.sv
// Top level of the pivot TRS matrix composer: config registers, rebuild and row datapath.
// One row of an existing matrix enters per clock while in_stall is low and passes through
// the input, product and result registers, either multiplied by the composed matrix
// M = T(-pivot)*S*R*T(pivot)*T(translation) or, with has_group clear, as row row_index of M;
// elements are signed with ELEM_FRAC_BITS fraction bits and saturate to 32 bits. A write to
// a register index 0..4 rebuilds M: three CORDIC runs, then 45 multiply-accumulate ops on a
// 17x36 digit-serial multiplier; in_stall stays high during the write cycle and the whole
// rebuild. Rows stream one per clock otherwise, limited only by out_stall.
module pivot_trs_matrix_compose #(
    parameter int ELEM_FRAC_BITS  = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [trs_pkg::REG_IDX_W-1:0]       cfg_addr,
    input  logic [trs_pkg::REG_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          row_index,
    input  logic                                has_group,
    input  logic signed [31:0]                  elem_0,
    input  logic signed [31:0]                  elem_1,
    input  logic signed [31:0]                  elem_2,
    input  logic signed [31:0]                  elem_3,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  out_0,
    output logic signed [31:0]                  out_1,
    output logic signed [31:0]                  out_2,
    output logic signed [31:0]                  out_3
);

    trs_pkg::cfg_t cfg_reg;
    trs_pkg::mat_t mat;
    logic          cfg_hit;
    logic          build_busy;
    logic          hold;

    assign cfg_hit = cfg_wr_en &&
                     ((cfg_addr == trs_pkg::REG_SCALE) || (cfg_addr == trs_pkg::REG_USCALE) ||
                      (cfg_addr == trs_pkg::REG_ROT)   || (cfg_addr == trs_pkg::REG_TRANS)  ||
                      (cfg_addr == trs_pkg::REG_PIVOT));
    assign hold = cfg_wr_en || build_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale  <= trs_pkg::SCALE_RST;
            cfg_reg.uscale <= trs_pkg::USCALE_RST;
            cfg_reg.rot    <= '0;
            cfg_reg.trans  <= '0;
            cfg_reg.pivot  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (trs_pkg::reg_idx_t'(cfg_addr))
                trs_pkg::REG_SCALE:  cfg_reg.scale  <= cfg_wdata;
                trs_pkg::REG_USCALE: cfg_reg.uscale <= cfg_wdata[trs_pkg::CW-1:0];
                trs_pkg::REG_ROT:    cfg_reg.rot    <= cfg_wdata;
                trs_pkg::REG_TRANS:  cfg_reg.trans  <= cfg_wdata;
                trs_pkg::REG_PIVOT:  cfg_reg.pivot  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    trs_builder #(
        .ELEM_FRAC_BITS (ELEM_FRAC_BITS),
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_builder (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cfg_hit),
        .cfg  (cfg_reg),
        .busy (build_busy),
        .mat  (mat)
    );

    trs_row_mac #(
        .ELEM_FRAC_BITS(ELEM_FRAC_BITS)
    ) u_row_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (hold),
        .mat      (mat),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .row_index(row_index),
        .has_group(has_group),
        .elem_0   (elem_0),
        .elem_1   (elem_1),
        .elem_2   (elem_2),
        .elem_3   (elem_3),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_0    (out_0),
        .out_1    (out_1),
        .out_2    (out_2),
        .out_3    (out_3)
    );

    // a register write always launches a rebuild
    a_rebuild_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> build_busy)
        else $error("rebuild did not start after register write");

    // no request enters while the matrix is being rebuilt
    a_no_accept_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        build_busy |-> in_stall)
        else $error("request accepted during rebuild");

endmodule

>>> rtl/trs_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of half an angle given in 1/1024 degrees.
module trs_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [trs_pkg::CW-1:0]      angle,
    output logic                               done,
    output logic signed [trs_pkg::ANG_W-1:0]   sin_val,
    output logic signed [trs_pkg::ANG_W-1:0]   cos_val
);

    localparam int IW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
    localparam logic [IW-1:0] LAST = IW'(TRIG_ITERATIONS - 1);

    logic signed [21:0] a_w;
    logic signed [21:0] a_f;
    logic               flip;
    logic signed [55:0] zp;
    logic signed [trs_pkg::ANG_W-1:0] z0;
    logic signed [trs_pkg::ANG_W-1:0] xs;
    logic signed [trs_pkg::ANG_W-1:0] ys;
    logic signed [trs_pkg::ANG_W-1:0] at;

    logic signed [trs_pkg::ANG_W-1:0] x_reg;
    logic signed [trs_pkg::ANG_W-1:0] y_reg;
    logic signed [trs_pkg::ANG_W-1:0] z_reg;
    logic                             flip_reg;
    logic [IW-1:0]                    iter_reg;
    logic                             run_reg;
    logic                             done_reg;

    always_comb
    begin
        a_w = 22'(angle);
        if (a_w >= 22'sd368640)
            a_w = a_w - 22'sd737280;
        if (a_w < -22'sd368640)
            a_w = a_w + 22'sd737280;
        flip = 1'b0;
        a_f  = a_w;
        if (a_w > 22'sd184320)
        begin
            a_f  = 22'sd368640 - a_w;
            flip = 1'b1;
        end
        else if (a_w < -22'sd184320)
        begin
            a_f  = -22'sd368640 - a_w;
            flip = 1'b1;
        end
        zp = 56'(a_f) * 56'sd599690565 + 56'sd32768;
        z0 = trs_pkg::ANG_W'(zp >>> 16);
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = trs_pkg::atan_q30(5'(iter_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= 34'sd652032874;
                y_reg    <= '0;
                z_reg    <= z0;
                flip_reg <= flip;
                iter_reg <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                if (!z_reg[trs_pkg::ANG_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                if (iter_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + IW'(1);
                end
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = y_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;

endmodule

>>> rtl/trs_builder.sv
// Matrix rebuild sequencer: shared CORDIC and a digit-serial multiply-accumulate unit.
module trs_builder #(
    parameter int ELEM_FRAC_BITS  = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  trs_pkg::cfg_t cfg,
    output logic          busy,
    output trs_pkg::mat_t mat
);

    localparam int ACC_W = trs_pkg::ACC_W;
    localparam int ANG_W = trs_pkg::ANG_W;
    localparam int OPB_W = trs_pkg::OPB_W;
    localparam int RND_M_SH = 50 - ELEM_FRAC_BITS;
    localparam int RND_T_SH = 60 - ELEM_FRAC_BITS;
    localparam logic [trs_pkg::ELEM_W-1:0] ELEM_ONE = 32'd1 << ELEM_FRAC_BITS;
    localparam trs_pkg::mat_t MAT_ID = {ELEM_ONE, 128'd0, ELEM_ONE, 128'd0,
                                        ELEM_ONE, 128'd0, ELEM_ONE};
    localparam logic signed [OPB_W-1:0] ONE_Q30 = 36'sd1073741824;

    localparam logic [5:0] OP_S    = 6'd0;
    localparam logic [5:0] OP_PS   = 6'd3;
    localparam logic [5:0] OP_MQ   = 6'd6;
    localparam logic [5:0] OP_M    = 6'd27;
    localparam logic [5:0] OP_T    = 6'd36;
    localparam logic [5:0] OP_LAST = 6'd44;

    localparam logic [2:0] PH_INIT = 3'd0;
    localparam logic [2:0] PH_WB   = 3'd5;

    typedef enum logic [1:0] {ST_IDLE, ST_TRIG, ST_MAC} state_t;

    typedef enum logic [4:0] {
        MQ_CYSP, MQ_QX1, MQ_SYCP, MQ_QX2, MQ_QY1, MQ_QY2, MQ_CYCP, MQ_QZ1,
        MQ_SYSP, MQ_QZ2, MQ_QW1, MQ_QW2, MQ_XX, MQ_YY, MQ_ZZ, MQ_XY,
        MQ_WZ, MQ_XZ, MQ_WY, MQ_YZ, MQ_WX
    } mq_t;
    localparam int MQ_NUM = 21;

    // n -> {n/3, n%3} for n below nine
    function automatic logic [3:0] rc_of(input logic [3:0] n);
        logic [3:0] r;
        case (n)
            4'd0:    r = 4'b00_00;
            4'd1:    r = 4'b00_01;
            4'd2:    r = 4'b00_10;
            4'd3:    r = 4'b01_00;
            4'd4:    r = 4'b01_01;
            4'd5:    r = 4'b01_10;
            4'd6:    r = 4'b10_00;
            4'd7:    r = 4'b10_01;
            4'd8:    r = 4'b10_10;
            default: r = 4'b00_00;
        endcase
        return r;
    endfunction

    state_t state_reg;
    logic [1:0] trig_k_reg;
    logic       cor_go_reg;
    logic [5:0] op_reg;
    logic [2:0] ph_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [41:0] s_reg [3];
    logic signed [63:0] nps_reg [3];
    logic signed [ANG_W-1:0] sn_reg [3];
    logic signed [ANG_W-1:0] cs_reg [3];
    logic signed [ANG_W-1:0] mqv_reg [MQ_NUM];
    trs_pkg::mat_t mat_reg;

    logic                    cor_done;
    logic signed [ANG_W-1:0] cor_sin;
    logic signed [ANG_W-1:0] cor_cos;

    logic signed [trs_pkg::CW-1:0] u_w;
    logic signed [ANG_W:0]   qx, qy, qz, qw;
    logic signed [ANG_W:0]   qa, qb;
    logic signed [OPB_W-1:0] r_w [3][3];
    logic [3:0] rc_m, rc_t;
    logic [4:0] n_q;
    logic [1:0] sidx;
    logic signed [41:0] s_rd;
    logic signed [63:0] nps_rd;
    logic signed [63:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [ACC_W-1:0] init_v;
    logic                    init_en;
    logic [1:0]              dsel;
    logic [15:0]             dig_raw;
    logic signed [16:0]      dig17;
    logic signed [52:0]      pp_m;
    logic signed [ACC_W-1:0] pp;

    trs_cordic #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_go_reg),
        .angle  (trs_pkg::comp(cfg.rot, trig_k_reg)),
        .done   (cor_done),
        .sin_val(cor_sin),
        .cos_val(cor_cos)
    );

    assign u_w = cfg.uscale;
    assign qx = (ANG_W+1)'(mqv_reg[MQ_QX1]) + (ANG_W+1)'(mqv_reg[MQ_QX2]);
    assign qy = (ANG_W+1)'(mqv_reg[MQ_QY1]) - (ANG_W+1)'(mqv_reg[MQ_QY2]);
    assign qz = (ANG_W+1)'(mqv_reg[MQ_QZ1]) - (ANG_W+1)'(mqv_reg[MQ_QZ2]);
    assign qw = (ANG_W+1)'(mqv_reg[MQ_QW1]) + (ANG_W+1)'(mqv_reg[MQ_QW2]);

    always_comb
    begin
        logic signed [OPB_W-1:0] xx, yy, zz, xy, wz, xz, wy, yz, wx;
        xx = OPB_W'(mqv_reg[MQ_XX]);
        yy = OPB_W'(mqv_reg[MQ_YY]);
        zz = OPB_W'(mqv_reg[MQ_ZZ]);
        xy = OPB_W'(mqv_reg[MQ_XY]);
        wz = OPB_W'(mqv_reg[MQ_WZ]);
        xz = OPB_W'(mqv_reg[MQ_XZ]);
        wy = OPB_W'(mqv_reg[MQ_WY]);
        yz = OPB_W'(mqv_reg[MQ_YZ]);
        wx = OPB_W'(mqv_reg[MQ_WX]);
        r_w[0][0] = ONE_Q30 - ((yy + zz) <<< 1);
        r_w[0][1] = (xy + wz) <<< 1;
        r_w[0][2] = (xz - wy) <<< 1;
        r_w[1][0] = (xy - wz) <<< 1;
        r_w[1][1] = ONE_Q30 - ((zz + xx) <<< 1);
        r_w[1][2] = (yz + wx) <<< 1;
        r_w[2][0] = (xz + wy) <<< 1;
        r_w[2][1] = (yz - wx) <<< 1;
        r_w[2][2] = ONE_Q30 - ((yy + xx) <<< 1);
    end

    // operand and init selection for the current op
    always_comb
    begin
        rc_m    = rc_of(4'(op_reg - OP_M));
        rc_t    = rc_of(4'(op_reg - OP_T));
        n_q     = 5'(op_reg - OP_MQ);
        qa      = '0;
        qb      = '0;
        init_v  = '0;
        init_en = 1'b1;
        if (op_reg < OP_PS)
            sidx = op_reg[1:0];
        else if (op_reg < OP_MQ)
            sidx = 2'(op_reg - OP_PS);
        else if (op_reg < OP_T)
            sidx = rc_m[3:2];
        else
            sidx = rc_t[1:0];
        s_rd   = s_reg[sidx];
        nps_rd = nps_reg[sidx];

        case (mq_t'(n_q))
            MQ_CYSP: begin qa = cs_reg[1];          qb = sn_reg[0]; end
            MQ_QX1:  begin qa = mqv_reg[MQ_CYSP];   qb = cs_reg[2]; end
            MQ_SYCP: begin qa = sn_reg[1];          qb = cs_reg[0]; end
            MQ_QX2:  begin qa = mqv_reg[MQ_SYCP];   qb = sn_reg[2]; end
            MQ_QY1:  begin qa = mqv_reg[MQ_SYCP];   qb = cs_reg[2]; end
            MQ_QY2:  begin qa = mqv_reg[MQ_CYSP];   qb = sn_reg[2]; end
            MQ_CYCP: begin qa = cs_reg[1];          qb = cs_reg[0]; end
            MQ_QZ1:  begin qa = mqv_reg[MQ_CYCP];   qb = sn_reg[2]; end
            MQ_SYSP: begin qa = sn_reg[1];          qb = sn_reg[0]; end
            MQ_QZ2:  begin qa = mqv_reg[MQ_SYSP];   qb = cs_reg[2]; end
            MQ_QW1:  begin qa = mqv_reg[MQ_CYCP];   qb = cs_reg[2]; end
            MQ_QW2:  begin qa = mqv_reg[MQ_SYSP];   qb = sn_reg[2]; end
            MQ_XX:   begin qa = qx; qb = qx; end
            MQ_YY:   begin qa = qy; qb = qy; end
            MQ_ZZ:   begin qa = qz; qb = qz; end
            MQ_XY:   begin qa = qx; qb = qy; end
            MQ_WZ:   begin qa = qz; qb = qw; end
            MQ_XZ:   begin qa = qz; qb = qx; end
            MQ_WY:   begin qa = qy; qb = qw; end
            MQ_YZ:   begin qa = qy; qb = qz; end
            MQ_WX:   begin qa = qx; qb = qw; end
            default: begin qa = '0; qb = '0; end
        endcase

        if (op_reg < OP_PS)
        begin
            op_a = 64'(trs_pkg::comp(cfg.scale, sidx));
            op_b = OPB_W'(u_w);
        end
        else if (op_reg < OP_MQ)
        begin
            op_a = 64'(s_rd);
            op_b = OPB_W'(trs_pkg::comp(cfg.pivot, sidx));
        end
        else if (op_reg < OP_M)
        begin
            op_a   = 64'(qa);
            op_b   = OPB_W'(qb);
            init_v = ACC_W'(1) <<< 29;
        end
        else if (op_reg < OP_T)
        begin
            op_a   = 64'(s_rd);
            op_b   = r_w[rc_m[3:2]][rc_m[1:0]];
            init_v = ACC_W'(1) <<< (RND_M_SH - 1);
        end
        else
        begin
            op_a    = nps_rd;
            op_b    = r_w[rc_t[1:0]][rc_t[3:2]];
            init_en = (rc_t[1:0] == 2'd0);
            init_v  = ((ACC_W'(trs_pkg::comp(cfg.pivot, rc_t[3:2]))
                      + ACC_W'(trs_pkg::comp(cfg.trans, rc_t[3:2]))) <<< 50)
                      + (ACC_W'(1) <<< (RND_T_SH - 1));
        end

        dsel    = 2'(ph_reg - 3'd1);
        dig_raw = op_a[{dsel, 4'b0000} +: 16];
        dig17   = (dsel == 2'd3) ? {dig_raw[15], dig_raw} : {1'b0, dig_raw};
        pp_m    = dig17 * op_b;
        pp      = ACC_W'(pp_m) <<< {dsel, 4'b0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            trig_k_reg <= '0;
            cor_go_reg <= 1'b0;
            op_reg     <= OP_S;
            ph_reg     <= PH_INIT;
            mat_reg    <= MAT_ID;
        end
        else
        begin
            cor_go_reg <= 1'b0;
            if (start)
            begin
                state_reg  <= ST_TRIG;
                trig_k_reg <= '0;
                cor_go_reg <= 1'b1;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                    end
                    ST_TRIG:
                    begin
                        if (cor_done)
                        begin
                            sn_reg[trig_k_reg] <= cor_sin;
                            cs_reg[trig_k_reg] <= cor_cos;
                            if (trig_k_reg == 2'd2)
                            begin
                                state_reg <= ST_MAC;
                                op_reg    <= OP_S;
                                ph_reg    <= PH_INIT;
                            end
                            else
                            begin
                                trig_k_reg <= trig_k_reg + 2'd1;
                                cor_go_reg <= 1'b1;
                            end
                        end
                    end
                    ST_MAC:
                    begin
                        if (ph_reg == PH_INIT)
                        begin
                            if (init_en)
                                acc_reg <= init_v;
                            ph_reg <= ph_reg + 3'd1;
                        end
                        else if (ph_reg == PH_WB)
                        begin
                            if (op_reg < OP_PS)
                                s_reg[sidx] <= acc_reg[41:0];
                            else if (op_reg < OP_MQ)
                                nps_reg[sidx] <= -acc_reg[63:0];
                            else if (op_reg < OP_M)
                                mqv_reg[n_q] <= ANG_W'(acc_reg >>> 30);
                            else if (op_reg < OP_T)
                                mat_reg[rc_m] <= trs_pkg::sat32(acc_reg, RND_M_SH);
                            else if (rc_t[1:0] == 2'd2)
                                mat_reg[{2'b11, rc_t[3:2]}] <=
                                    trs_pkg::sat32(acc_reg, RND_T_SH);
                            if (op_reg == OP_LAST)
                                state_reg <= ST_IDLE;
                            else
                            begin
                                op_reg <= op_reg + 6'd1;
                                ph_reg <= PH_INIT;
                            end
                        end
                        else
                        begin
                            acc_reg <= acc_reg + pp;
                            ph_reg  <= ph_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign mat  = mat_reg;

endmodule

>>> rtl/trs_row_mac.sv
// Row-times-matrix datapath: input register, product register, saturated result register.
module trs_row_mac #(
    parameter int ELEM_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hold,
    input  trs_pkg::mat_t       mat,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          row_index,
    input  logic                has_group,
    input  logic signed [31:0]  elem_0,
    input  logic signed [31:0]  elem_1,
    input  logic signed [31:0]  elem_2,
    input  logic signed [31:0]  elem_3,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_0,
    output logic signed [31:0]  out_1,
    output logic signed [31:0]  out_2,
    output logic signed [31:0]  out_3
);

    localparam int ACC_W = trs_pkg::ACC_W;

    logic advance;
    logic accept;

    logic              v1_reg;
    logic [1:0]        row1_reg;
    logic              grp1_reg;
    logic signed [31:0] e_reg [4];

    logic              v2_reg;
    logic [1:0]        row2_reg;
    logic              grp2_reg;
    logic signed [63:0] prod_reg [4][4];

    logic              outv_reg;
    logic [31:0]       res_reg [4];

    logic [31:0]       res_next [4];

    assign advance  = !outv_reg || !out_stall;
    assign in_stall = hold || !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        logic signed [ACC_W-1:0] sum;
        for (int j = 0; j < 4; j++)
        begin
            sum = ACC_W'(1) <<< (ELEM_FRAC_BITS - 1);
            for (int k = 0; k < 4; k++)
                sum = sum + ACC_W'(prod_reg[k][j]);
            if (grp2_reg)
                res_next[j] = trs_pkg::sat32(sum, ELEM_FRAC_BITS);
            else
                res_next[j] = mat[{row2_reg, 2'(j)}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            outv_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            outv_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row1_reg <= row_index;
            grp1_reg <= has_group;
            e_reg[0] <= elem_0;
            e_reg[1] <= elem_1;
            e_reg[2] <= elem_2;
            e_reg[3] <= elem_3;
            row2_reg <= row1_reg;
            grp2_reg <= grp1_reg;
            for (int k = 0; k < 4; k++)
                for (int j = 0; j < 4; j++)
                    prod_reg[k][j] <= 64'(e_reg[k]) * 64'($signed(mat[4 * k + j]));
            for (int j = 0; j < 4; j++)
                res_reg[j] <= res_next[j];
        end
    end

    assign out_valid = outv_reg;
    assign out_0 = res_reg[0];
    assign out_1 = res_reg[1];
    assign out_2 = res_reg[2];
    assign out_3 = res_reg[3];

endmodule
